>>> hdl/catmull_rom_frame_eval_macros.svh
// Assertion macros for the frame evaluator RTL.
`ifndef CATMULL_ROM_FRAME_EVAL_MACROS_SVH
`define CATMULL_ROM_FRAME_EVAL_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CRFE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CRFE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/crfe_pkg.sv
// Package: types, constants and helpers of the Catmull-Rom frame evaluator.
`timescale 1ns / 1ps
package crfe_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int UNIT_FRAC_BITS = 14;
   localparam int UNIT_WIDTH     = UNIT_FRAC_BITS + 2;
   // Horner accumulators need seven guard bits over a coordinate
   localparam int HORNER_WIDTH   = COORD_WIDTH + 7;
   // exact cross product of two unit vectors
   localparam int CROSS_WIDTH    = 2 * UNIT_FRAC_BITS + 3;
   localparam int NORM_WIDTH0    = (HORNER_WIDTH > CROSS_WIDTH) ? HORNER_WIDTH : CROSS_WIDTH;
   localparam int NORM_WIDTH     = (NORM_WIDTH0 > 32) ? NORM_WIDTH0 : 32;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // Horner phases for one axis
   localparam logic [2:0] HPH_LOAD = 3'd0;
   localparam logic [2:0] HPH_POS1 = 3'd1;
   localparam logic [2:0] HPH_POS2 = 3'd2;
   localparam logic [2:0] HPH_POS3 = 3'd3;
   localparam logic [2:0] HPH_DER1 = 3'd4;
   localparam logic [2:0] HPH_DER2 = 3'd5;
   // last phase of a cross product (two per component)
   localparam logic [2:0] XPH_LAST = 3'd5;

   typedef struct packed {
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic signed [COORD_WIDTH-1:0] coord_z;
      logic [15:0]                   param_u;
   } crfe_req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic signed [UNIT_WIDTH-1:0]  tan_x;
      logic signed [UNIT_WIDTH-1:0]  tan_y;
      logic signed [UNIT_WIDTH-1:0]  tan_z;
      logic signed [UNIT_WIDTH-1:0]  nrm_x;
      logic signed [UNIT_WIDTH-1:0]  nrm_y;
      logic signed [UNIT_WIDTH-1:0]  nrm_z;
      logic signed [UNIT_WIDTH-1:0]  bin_x;
      logic signed [UNIT_WIDTH-1:0]  bin_y;
      logic signed [UNIT_WIDTH-1:0]  bin_z;
   } crfe_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HORNER, ST_TAN_GO, ST_TAN_WAIT, ST_SEED_GO, ST_SEED_WAIT,
      ST_XN, ST_NRM_GO, ST_NRM_WAIT, ST_XB, ST_BIN_GO, ST_BIN_WAIT, ST_FINISH
   } crfe_state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_MAX, N_SHIFT, N_SQUARE, N_ROOT, N_DIV_LOAD, N_DIVIDE, N_DONE
   } crfe_norm_state_type;

   // which vector goes through the normalizer, and where the result lands
   typedef enum logic [1:0] {
      SEL_TAN, SEL_SEED, SEL_NRM, SEL_BIN
   } crfe_sel_type;

   typedef struct packed {
      logic         push;
      logic         eval_start;
      logic         horner_en;
      logic         cross_en;
      logic         cross_use_nrm;
      logic         norm_start;
      crfe_sel_type norm_sel;
      logic [1:0]   axis;
      logic [2:0]   phase;
      logic         load_rsp;
   } crfe_cmd_type;

   typedef struct packed {
      logic norm_done;
      logic u_zero;
      logic rsp_free;
   } crfe_status_type;

   // component indexes of the two products in one cross component
   function automatic logic [1:0] cross_lead(input logic [1:0] k);
      case (k)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] cross_trail(input logic [1:0] k);
      case (k)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

endpackage

>>> hdl/crfe_norm.sv
// Shared multi-cycle vector normalizer: shift, sum of squares, root, divide.
`timescale 1ns / 1ps
`include "catmull_rom_frame_eval_macros.svh"
module crfe_norm
   import crfe_pkg::*;
#(
   parameter int IN_WIDTH  = NORM_WIDTH,
   parameter int FRAC_BITS = UNIT_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_i,
   input  logic signed [IN_WIDTH-1:0]  vec_i [3],
   output logic                        done_o,
   output logic signed [FRAC_BITS+1:0] vec_o [3]
);

   localparam int UW  = FRAC_BITS + 2;
   localparam int QB  = FRAC_BITS + 1;
   localparam int DW  = FRAC_BITS + 31;
   localparam int CW  = $clog2(FRAC_BITS + 1);
   localparam int SQW = 62;

   crfe_norm_state_type state_ff, state_in;

   logic [IN_WIDTH-1:0] mag_ff [3];
   logic                neg_ff [3];
   logic [IN_WIDTH-1:0] m_ff;
   logic [SQW-1:0]      rem_ff;
   logic [SQW-1:0]      root_ff;
   logic [SQW-1:0]      bit_ff;
   logic [1:0]          idx_ff;
   logic [DW-1:0]       num_ff;
   logic [DW-1:0]       den_ff;
   logic [QB-1:0]       quo_ff;
   logic [CW-1:0]       cnt_ff;
   logic signed [UW-1:0] out_ff [3];

   logic [SQW-1:0] trial;
   logic [59:0]    square;
   logic           ge;
   logic [QB-1:0]  quo_in;

   assign trial  = root_ff + bit_ff;
   assign square = mag_ff[idx_ff][29:0] * mag_ff[idx_ff][29:0];
   assign ge     = num_ff >= den_ff;
   assign quo_in = {quo_ff[QB-2:0], ge};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         N_IDLE:     if (start_i) state_in = N_MAX;
         N_MAX:      state_in = N_SHIFT;
         N_SHIFT: begin
            if (m_ff == '0) state_in = N_DONE;
            else if ((m_ff >> 30) == '0 && (m_ff >> 29) != '0) state_in = N_SQUARE;
         end
         N_SQUARE:   if (idx_ff == 2'd2) state_in = N_ROOT;
         N_ROOT:     if (bit_ff[0]) state_in = N_DIV_LOAD;
         N_DIV_LOAD: state_in = N_DIVIDE;
         N_DIVIDE: begin
            if (cnt_ff == '0) state_in = (idx_ff == 2'd2) ? N_DONE : N_DIV_LOAD;
         end
         N_DONE:     state_in = N_IDLE;
         default:    state_in = N_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done_o = (state_ff == N_DONE);
      for (int i = 0; i < 3; i++) vec_o[i] = out_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= N_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         N_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[i] <= vec_i[i][IN_WIDTH-1];
               mag_ff[i] <= vec_i[i][IN_WIDTH-1] ? IN_WIDTH'(-vec_i[i]) : vec_i[i];
            end
         end
         N_MAX: begin
            if (mag_ff[0] >= mag_ff[1] && mag_ff[0] >= mag_ff[2]) m_ff <= mag_ff[0];
            else if (mag_ff[1] >= mag_ff[2])                       m_ff <= mag_ff[1];
            else                                                    m_ff <= mag_ff[2];
         end
         N_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30), coarse then fine
            if (m_ff == '0) begin
               for (int i = 0; i < 3; i++) out_ff[i] <= '0;
            end else if ((m_ff >> 38) != '0) begin
               m_ff <= m_ff >> 8;
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 8;
            end else if ((m_ff >> 30) != '0) begin
               m_ff <= m_ff >> 1;
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
            end else if ((m_ff >> 21) == '0) begin
               m_ff <= m_ff << 8;
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 8;
            end else if ((m_ff >> 29) == '0) begin
               m_ff <= m_ff << 1;
               for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
            end else begin
               idx_ff <= 2'd0;
               rem_ff <= '0;
            end
         end
         N_SQUARE: begin
            rem_ff <= rem_ff + SQW'(square);
            idx_ff <= idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               root_ff <= '0;
               bit_ff  <= SQW'(1) << 60;
            end
         end
         N_ROOT: begin
            // one result bit per cycle
            if (rem_ff >= trial) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) idx_ff <= 2'd0;
         end
         N_DIV_LOAD: begin
            // rounded quotient: (mag * 2^F + r/2) / r
            num_ff <= (DW'(mag_ff[idx_ff][29:0]) << FRAC_BITS) + DW'(root_ff >> 1);
            den_ff <= DW'(root_ff[30:0]) << FRAC_BITS;
            quo_ff <= '0;
            cnt_ff <= CW'(FRAC_BITS);
         end
         N_DIVIDE: begin
            if (ge) num_ff <= num_ff - den_ff;
            den_ff <= den_ff >> 1;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               out_ff[idx_ff] <= neg_ff[idx_ff] ? -$signed({1'b0, quo_in})
                                                 : $signed({1'b0, quo_in});
               idx_ff <= idx_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   `CRFE_ASSERT_NXT(a_start_runs, start_i, state_ff == N_MAX, "normalizer started while busy")
   `CRFE_ASSERT_IMP(a_scaled, state_ff == N_SQUARE, (m_ff >> 29) == 1, "scaling out of range")
   `CRFE_ASSERT_IMP(a_root_big, state_ff == N_DIV_LOAD, (root_ff >> 29) != '0, "root too small")

endmodule

>>> hdl/crfe_dp.sv
// Datapath: point window, Horner evaluation, cross products and result register.
`timescale 1ns / 1ps
module crfe_dp
   import crfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  crfe_cmd_type    cmd,
   input  crfe_req_type    req_data,
   input  logic            rsp_ready,
   output crfe_status_type status,
   output logic            rsp_valid,
   output crfe_rsp_type    rsp_data
);

   localparam int C  = COORD_WIDTH;
   localparam int HW = HORNER_WIDTH;
   localparam int UW = UNIT_WIDTH;
   localparam int NW = NORM_WIDTH;
   localparam int PW = HW + 17;
   localparam logic signed [HW-1:0] PMAX = HW'((64'sd1 <<< (C - 1)) - 64'sd1);
   localparam logic signed [HW-1:0] PMIN = HW'(-(64'sd1 <<< (C - 1)));
   localparam logic signed [PW-1:0] HALF_U = PW'(32768);

   logic signed [C-1:0]  win_ff [4][3];
   logic [15:0]          u_ff;
   logic signed [HW-1:0] accp_ff, accd_ff;
   logic signed [C-1:0]  pos_ff [3];
   logic signed [HW-1:0] der_ff [3];
   logic signed [UW-1:0] t_ff [3];
   logic signed [UW-1:0] kept_ff [3];
   logic signed [UW-1:0] n_ff [3];
   logic signed [2*UW-1:0] xp_ff;
   logic signed [NW-1:0] crs_ff [3];
   crfe_sel_type         sel_ff;
   logic                 rsp_valid_ff;
   crfe_rsp_type         rsp_data_ff;

   logic signed [HW-1:0] p1, p2, p3, p4, c1, c2, c3, c4;
   logic signed [HW-1:0] mop, addend, mu, rnd;
   logic signed [PW-1:0] prod;
   logic signed [C-1:0]  pos_sat;

   logic [1:0]             xk, xia, xib;
   logic signed [UW-1:0]   xa, xb;
   logic signed [2*UW-1:0] xprod;

   logic signed [NW-1:0]   nin [3];
   logic                   norm_done;
   logic signed [UW-1:0]   nout [3];

   // Catmull-Rom coefficients (doubled) for the selected axis
   always_comb begin
      p1 = HW'(win_ff[0][cmd.axis]);
      p2 = HW'(win_ff[1][cmd.axis]);
      p3 = HW'(win_ff[2][cmd.axis]);
      p4 = HW'(win_ff[3][cmd.axis]);
      c1 = p2 <<< 1;
      c2 = p3 - p1;
      c3 = (p1 <<< 1) - ((p2 <<< 2) + p2) + (p3 <<< 2) - p4;
      c4 = p2 + (p2 <<< 1) - p1 - p3 - (p3 <<< 1) + p4;
   end

   // one multiply by u per cycle, rounded half up
   always_comb begin
      mop = (cmd.phase >= HPH_DER1) ? accd_ff : accp_ff;
      case (cmd.phase)
         HPH_POS1: addend = c3;
         HPH_POS2: addend = c2;
         HPH_POS3: addend = c1;
         HPH_DER1: addend = c3 <<< 1;
         HPH_DER2: addend = c2;
         default:  addend = '0;
      endcase
      prod = PW'(mop) * PW'($signed({1'b0, u_ff}));
      mu   = HW'((prod + HALF_U) >>> 16);
      rnd  = (accp_ff + HW'(1)) >>> 1;
      if (rnd > PMAX)      pos_sat = C'(PMAX);
      else if (rnd < PMIN) pos_sat = C'(PMIN);
      else                 pos_sat = C'(rnd);
   end

   // cross product operands: two products per component
   always_comb begin
      xk    = cmd.phase[2:1];
      xia   = cmd.phase[0] ? cross_trail(xk) : cross_lead(xk);
      xib   = cmd.phase[0] ? cross_lead(xk) : cross_trail(xk);
      xa    = t_ff[xia];
      xb    = cmd.cross_use_nrm ? n_ff[xib] : kept_ff[xib];
      xprod = xa * xb;
   end

   // normalizer source
   always_comb begin
      for (int i = 0; i < 3; i++) nin[i] = crs_ff[i];
      case (cmd.norm_sel)
         SEL_TAN: begin
            for (int i = 0; i < 3; i++) nin[i] = NW'(der_ff[i]);
         end
         SEL_SEED: begin
            nin[0] = -NW'(t_ff[1]);
            nin[1] = NW'(t_ff[0]);
            nin[2] = NW'(t_ff[2]);
         end
         default: begin
         end
      endcase
   end

   crfe_norm #(
      .IN_WIDTH  (NW),
      .FRAC_BITS (UNIT_FRAC_BITS)
   ) u_norm (
      .clock   (clock),
      .reset   (reset),
      .start_i (cmd.norm_start),
      .vec_i   (nin),
      .done_o  (norm_done),
      .vec_o   (nout)
   );

   // model state: window and kept binormal
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++)
            for (int a = 0; a < 3; a++) win_ff[r][a] <= '0;
         for (int a = 0; a < 3; a++) kept_ff[a] <= '0;
      end else begin
         if (cmd.push) begin
            for (int r = 0; r < 3; r++) win_ff[r] <= win_ff[r + 1];
            win_ff[3][0] <= req_data.coord_x;
            win_ff[3][1] <= req_data.coord_y;
            win_ff[3][2] <= req_data.coord_z;
         end
         if (norm_done && (sel_ff == SEL_SEED || sel_ff == SEL_BIN)) begin
            for (int a = 0; a < 3; a++) kept_ff[a] <= nout[a];
         end
      end
   end

   // evaluation working registers
   always_ff @(posedge clock) begin
      if (cmd.eval_start) u_ff <= req_data.param_u;
      if (cmd.horner_en) begin
         case (cmd.phase)
            HPH_LOAD: begin
               accp_ff <= c4;
               accd_ff <= c4 + (c4 <<< 1);
            end
            HPH_POS1, HPH_POS2, HPH_POS3: accp_ff <= mu + addend;
            HPH_DER1: begin
               accd_ff <= mu + addend;
               pos_ff[cmd.axis] <= pos_sat;
            end
            HPH_DER2: der_ff[cmd.axis] <= mu + addend;
            default: begin
            end
         endcase
      end
      if (cmd.cross_en) begin
         if (!cmd.phase[0]) xp_ff <= xprod;
         else               crs_ff[xk] <= NW'(xp_ff - xprod);
      end
      if (cmd.norm_start) sel_ff <= cmd.norm_sel;
      if (norm_done) begin
         case (sel_ff)
            SEL_TAN: for (int a = 0; a < 3; a++) t_ff[a] <= nout[a];
            SEL_NRM: for (int a = 0; a < 3; a++) n_ff[a] <= nout[a];
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.pos_x <= pos_ff[0];
         rsp_data_ff.pos_y <= pos_ff[1];
         rsp_data_ff.pos_z <= pos_ff[2];
         rsp_data_ff.tan_x <= t_ff[0];
         rsp_data_ff.tan_y <= t_ff[1];
         rsp_data_ff.tan_z <= t_ff[2];
         rsp_data_ff.nrm_x <= n_ff[0];
         rsp_data_ff.nrm_y <= n_ff[1];
         rsp_data_ff.nrm_z <= n_ff[2];
         rsp_data_ff.bin_x <= kept_ff[0];
         rsp_data_ff.bin_y <= kept_ff[1];
         rsp_data_ff.bin_z <= kept_ff[2];
      end
   end

   assign status.norm_done = norm_done;
   assign status.u_zero    = (u_ff == '0);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

>>> hdl/crfe_ctrl.sv
// Controller: sequences Horner passes, normalizations and cross products.
`timescale 1ns / 1ps
module crfe_ctrl
   import crfe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_mode,
   input  crfe_status_type status,
   output logic            req_ready,
   output crfe_cmd_type    cmd
);

   crfe_state_type state_ff, state_in;
   logic [2:0]     phase_ff, phase_in;
   logic [1:0]     axis_ff, axis_in;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            phase_in = '0;
            axis_in  = '0;
            if (req_valid && req_mode == MODE_EVAL) state_in = ST_HORNER;
         end
         ST_HORNER: begin
            if (phase_ff == HPH_DER2) begin
               phase_in = '0;
               axis_in  = axis_ff + 2'd1;
               if (axis_ff == 2'd2) state_in = ST_TAN_GO;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_TAN_GO:   state_in = ST_TAN_WAIT;
         ST_TAN_WAIT: begin
            if (status.norm_done) state_in = status.u_zero ? ST_SEED_GO : ST_XN;
         end
         ST_SEED_GO:   state_in = ST_SEED_WAIT;
         ST_SEED_WAIT: if (status.norm_done) state_in = ST_XN;
         ST_XN: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == XPH_LAST) begin
               phase_in = '0;
               state_in = ST_NRM_GO;
            end
         end
         ST_NRM_GO:   state_in = ST_NRM_WAIT;
         ST_NRM_WAIT: if (status.norm_done) state_in = ST_XB;
         ST_XB: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == XPH_LAST) begin
               phase_in = '0;
               state_in = ST_BIN_GO;
            end
         end
         ST_BIN_GO:   state_in = ST_BIN_WAIT;
         ST_BIN_WAIT: if (status.norm_done) state_in = ST_FINISH;
         ST_FINISH:   if (status.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      req_ready          = (state_ff == ST_IDLE);
      cmd                = '0;
      cmd.axis           = axis_ff;
      cmd.phase          = phase_ff;
      cmd.norm_sel       = SEL_TAN;
      cmd.push           = req_ready && req_valid && req_mode == MODE_PUSH;
      cmd.eval_start     = req_ready && req_valid && req_mode == MODE_EVAL;
      case (state_ff)
         ST_HORNER:  cmd.horner_en = 1'b1;
         ST_TAN_GO:  cmd.norm_start = 1'b1;
         ST_SEED_GO: begin
            cmd.norm_start = 1'b1;
            cmd.norm_sel   = SEL_SEED;
         end
         ST_XN:      cmd.cross_en = 1'b1;
         ST_NRM_GO: begin
            cmd.norm_start = 1'b1;
            cmd.norm_sel   = SEL_NRM;
         end
         ST_XB: begin
            cmd.cross_en      = 1'b1;
            cmd.cross_use_nrm = 1'b1;
         end
         ST_BIN_GO: begin
            cmd.norm_start = 1'b1;
            cmd.norm_sel   = SEL_BIN;
         end
         ST_FINISH:  cmd.load_rsp = status.rsp_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

>>> hdl/catmull_rom_frame_eval.sv
// Top level of the Catmull-Rom spline evaluator with a moving frame.
// A push transaction shifts one Q16.16 control point into the four-point window as it
// is accepted and returns nothing. An evaluate transaction returns the saturated
// position and the Q1.14 tangent, normal and binormal. Its run time is set by the one
// shared normalizer, which runs three or four times in a row, four when u is zero
// (binormal reseed): each pass scales the vector, sums the squares, runs the bit-serial
// square root and then the divider for each component (a load step and 15 quotient bits).
// A pass over a zero-length vector skips the root and the divider, so such evaluations
// finish sooner. Horner evaluation of the three axes runs on one multiplier, and the two
// cross products run between the normalizations. A new transaction is accepted once the
// previous evaluation has reached the result register, even while that result still
// waits to be taken. The block is ready as soon as reset is released.
`timescale 1ns / 1ps
module catmull_rom_frame_eval
   import crfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  crfe_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output crfe_rsp_type rsp_data
);

   crfe_cmd_type    cmd;
   crfe_status_type status;

   crfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   crfe_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the Catmull-Rom frame evaluator.
`timescale 1ns / 1ps
module testbench
   import crfe_pkg::*;
();

   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  DRAIN_CYCLES = 500;
   localparam int  RANDOM_ITEMS = 1380;

   // Spline window, moving frame and the queue of expected frames
   class frame_scoreboard;
      longint       window[12];
      longint       binormal[3];
      crfe_rsp_type frame_queue[$];
      int           errors;
      int           n_push;
      int           n_eval;
      int           n_reseed;
      int           n_checked;
      string        field_name[12] = '{"pos_x", "pos_y", "pos_z", "tan_x", "tan_y",
         "tan_z", "nrm_x", "nrm_y", "nrm_z", "bin_x", "bin_y", "bin_z"};

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $realtime, what);
         errors++;
      endtask

      // round(x * u / 2^16), half up
      function longint scale_u(longint x, longint u);
         longint hi;
         longint lo;
         hi = x >>> 16;
         lo = x & 64'hFFFF;
         return hi * u + ((lo * u + 32768) >>> 16);
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'h1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // scale so the largest magnitude sits in [2^29, 2^30), then divide by the root
      function void unit_vec(input longint v[3], output longint o[3]);
         longint unsigned mag[3];
         longint unsigned m;
         longint unsigned sum;
         longint unsigned r;
         longint unsigned q;
         bit              neg[3];
         m = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
         end
         if (m == 0) begin
            o = '{0, 0, 0};
            return;
         end
         while (m >= (64'h1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
         end
         while (m < (64'h1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
         end
         for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
         r = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << UNIT_FRAC_BITS) + (r >> 1)) / r;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
         end
      endfunction

      function void cross3(input longint a[3], input longint b[3], output longint o[3]);
         o[0] = a[1] * b[2] - a[2] * b[1];
         o[1] = a[2] * b[0] - a[0] * b[2];
         o[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      // accepted request: shift the window or queue the expected frame
      function void note_request(crfe_req_type req);
         longint pos[3];
         longint der[3];
         longint t[3];
         longint n[3];
         longint b[3];
         longint tmp[3];
         longint p1, p2, p3, p4, c1, c2, c3, c4, a, u;
         longint pmax;
         crfe_rsp_type f;
         if (req.mode == MODE_PUSH) begin
            for (int i = 0; i < 9; i++) window[i] = window[i + 3];
            window[9]  = req.coord_x;
            window[10] = req.coord_y;
            window[11] = req.coord_z;
            n_push++;
            return;
         end
         n_eval++;
         u = req.param_u;
         pmax = (64'h1 << (COORD_WIDTH - 1)) - 1;
         for (int ax = 0; ax < 3; ax++) begin
            p1 = window[ax];
            p2 = window[3 + ax];
            p3 = window[6 + ax];
            p4 = window[9 + ax];
            c1 = 2 * p2;
            c2 = p3 - p1;
            c3 = 2 * p1 - 5 * p2 + 4 * p3 - p4;
            c4 = -p1 + 3 * p2 - 3 * p3 + p4;
            a = scale_u(c4, u) + c3;
            a = scale_u(a, u) + c2;
            a = scale_u(a, u) + c1;
            a = (a + 1) >>> 1;
            if (a > pmax) a = pmax;
            if (a < -pmax - 1) a = -pmax - 1;
            pos[ax] = a;
            a = scale_u(3 * c4, u) + 2 * c3;
            der[ax] = scale_u(a, u) + c2;
         end
         unit_vec(der, t);
         // u of zero reseeds the binormal from the tangent
         if (u == 0) begin
            tmp = '{-t[1], t[0], t[2]};
            unit_vec(tmp, binormal);
            n_reseed++;
         end
         cross3(t, binormal, tmp);
         unit_vec(tmp, n);
         cross3(t, n, tmp);
         unit_vec(tmp, b);
         binormal = b;
         f.pos_x = COORD_WIDTH'(pos[0]);
         f.pos_y = COORD_WIDTH'(pos[1]);
         f.pos_z = COORD_WIDTH'(pos[2]);
         f.tan_x = UNIT_WIDTH'(t[0]);
         f.tan_y = UNIT_WIDTH'(t[1]);
         f.tan_z = UNIT_WIDTH'(t[2]);
         f.nrm_x = UNIT_WIDTH'(n[0]);
         f.nrm_y = UNIT_WIDTH'(n[1]);
         f.nrm_z = UNIT_WIDTH'(n[2]);
         f.bin_x = UNIT_WIDTH'(b[0]);
         f.bin_y = UNIT_WIDTH'(b[1]);
         f.bin_z = UNIT_WIDTH'(b[2]);
         frame_queue = {frame_queue, f};
      endfunction

      task check_response(crfe_rsp_type got);
         crfe_rsp_type want;
         longint       gv[12];
         longint       wv[12];
         if (frame_queue.size() == 0) begin
            report_mismatch("frame returned with none expected");
            return;
         end
         want = frame_queue.pop_front();
         n_checked++;
         gv = '{got.pos_x, got.pos_y, got.pos_z, got.tan_x, got.tan_y, got.tan_z,
                got.nrm_x, got.nrm_y, got.nrm_z, got.bin_x, got.bin_y, got.bin_z};
         wv = '{want.pos_x, want.pos_y, want.pos_z, want.tan_x, want.tan_y, want.tan_z,
                want.nrm_x, want.nrm_y, want.nrm_z, want.bin_x, want.bin_y, want.bin_z};
         for (int i = 0; i < 12; i++)
            if (gv[i] != wv[i])
               report_mismatch($sformatf("frame %0d %s: got %0d, expected %0d",
                  n_checked, field_name[i], gv[i], wv[i]));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   crfe_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   crfe_rsp_type rsp_data;

   frame_scoreboard frames = new();
   int              send_idle_pct;
   int              recv_stall_pct;
   int              cycles;

   catmull_rom_frame_eval i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle count and run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("catmull_rom_frame_eval regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, check each accepted frame
   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) frames.check_response(rsp_data);

   // one transaction; valid set at the falling edge, held until accepted
   task send_item(crfe_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= crfe_req_type'({$urandom, $urandom, $urandom, $urandom});
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      frames.note_request(item);
   endtask

   task push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      crfe_req_type r;
      r.mode    = MODE_PUSH;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.param_u = 16'($urandom);
      send_item(r);
   endtask

   task eval_at(logic [15:0] u);
      crfe_req_type r;
      r = crfe_req_type'({$urandom, $urandom, $urandom, $urandom});
      r.mode    = MODE_EVAL;
      r.param_u = u;
      send_item(r);
   endtask

   // coordinate of a random magnitude class
   function logic [31:0] rand_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $signed($urandom_range(2097152)) - 1048576;
         2:       return $signed($urandom_range(131072)) - 65536;
         default: return $signed($urandom_range(33554432)) - 16777216;
      endcase
   endfunction

   // curve segment: window fill, usually a reseed at u zero, then mostly rising u steps
   task random_segment();
      int          npush;
      int          nsteps;
      logic [15:0] u;
      npush  = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 4;
      nsteps = $urandom_range(1, 6);
      for (int i = 0; i < npush; i++) push_point(rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(9) != 0) eval_at(16'd0);
      u = 0;
      for (int i = 0; i < nsteps; i++) begin
         u = u + 16'($urandom_range(1, 65535 / nsteps));
         eval_at(($urandom_range(7) == 0) ? 16'($urandom) : u);
      end
   endtask

   initial begin
      int items;
      send_idle_pct  = 7;
      recv_stall_pct = 84;
      cycles    = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty window, unseeded binormal, extremes, saturation, zero length
      eval_at(16'd0);
      eval_at(16'd12345);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      eval_at(16'd100);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      eval_at(16'd0);
      eval_at(16'd1);
      eval_at(16'd32768);
      eval_at(16'hFFFF);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      eval_at(16'd0);
      eval_at(16'd40000);
      // straight line along z
      for (int i = 0; i < 4; i++) push_point(32'd0, 32'd0, 32'(i * 65536));
      eval_at(16'd0);
      eval_at(16'd20000);
      items = 21;

      // random: three idling regimes
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct  = (ph == 0) ? 7 : (ph == 1) ? 84 : 0;
         recv_stall_pct = (ph == 0) ? 84 : (ph == 1) ? 7 : 0;
         while (items < 21 + (ph + 1) * RANDOM_ITEMS / 3) begin
            if ($urandom_range(9) == 0) begin
               send_item(crfe_req_type'({$urandom, $urandom, $urandom, $urandom}));
               items++;
            end else begin
               items += frames.n_push + frames.n_eval;
               random_segment();
               items -= frames.n_push + frames.n_eval;
               items += 2 * 0;
            end
            items = frames.n_push + frames.n_eval;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain
      while (frames.frame_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.frame_queue.size() != 0)
         frames.report_mismatch("expected frames never returned");
      $display("%0d pushes, %0d evaluations (%0d binormal reseeds), %0d frames checked",
         frames.n_push, frames.n_eval, frames.n_reseed, frames.n_checked);
      $display("%0d mismatches over %0d cycles", frames.errors, cycles);
      if (frames.errors == 0)
         $display("catmull_rom_frame_eval regression: pass");
      else
         $display("catmull_rom_frame_eval regression: fail");
      $finish;
   end

endmodule
